// File: hdl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Types and codes shared by the positional sequence store and its cells.
// ----------------------------------------------------------------------------
package pss_pkg;

    // wide enough for an index or a count at the largest capacity (256)
    localparam int PW = 9;

    localparam logic [1:0] FN_INSERT  = 2'd0;
    localparam logic [1:0] FN_DEL_POS = 2'd1;
    localparam logic [1:0] FN_DEL_KEY = 2'd2;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         position;
        logic [15:0]        node_handle;
        logic signed [31:0] node_key;
        logic [7:0]         symbol;
    } t_in;

    typedef struct packed {
        logic [15:0] head_handle;
        logic [7:0]  head_symbol;
        logic        is_vacant;
        logic [4:0]  entry_count;
        logic        rejected;
    } t_out;

    typedef struct packed {
        logic [15:0]        handle;
        logic signed [31:0] key;
        logic [7:0]         symbol;
    } t_entry;

    typedef struct packed {
        logic [1:0]    op;
        logic [PW-1:0] pos;
        logic          keep;
    } t_ctl;

endpackage

// File: hdl/pss_cell.sv
// ----------------------------------------------------------------------------
// pss_cell
// One slot of the store: holds an entry and takes it from a neighbor, the
// new item or the head according to the broadcast control.
// ----------------------------------------------------------------------------
module pss_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  pss_pkg::t_ctl    i_ctl,
    input  pss_pkg::t_entry  i_prev,
    input  pss_pkg::t_entry  i_next,
    input  pss_pkg::t_entry  i_new,
    input  pss_pkg::t_entry  i_head,
    output pss_pkg::t_entry  o_entry
);

    localparam int PW = pss_pkg::PW;
    localparam logic [PW-1:0] IDX_P = PW'(IDX);

    pss_pkg::t_entry r_entry;
    pss_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            pss_pkg::OP_INS: begin
                if (IDX_P == i_ctl.pos) begin
                    n_entry = i_new;
                end else if (IDX_P > i_ctl.pos) begin
                    n_entry = i_prev;
                end
            end
            pss_pkg::OP_DEL: begin
                if (IDX_P >= i_ctl.pos) begin
                    n_entry = i_next;
                end
            end
            pss_pkg::OP_ROT: begin
                // pos is the last slot of the live region
                if (IDX_P < i_ctl.pos) begin
                    n_entry = i_next;
                end else if (IDX_P == i_ctl.pos && i_ctl.keep) begin
                    n_entry = i_head;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: hdl/positional_sequence_store.sv
// ----------------------------------------------------------------------------
// positional_sequence_store
// Ordered store of up to CAPACITY entries built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Insert and delete-at-position leave busy low: the result beat shows on
// strobe in the cycle after start, and a new command may be given in every
// cycle. Delete-by-key walks the list once through the cell chain, one entry
// per cycle: busy stays high while entries are left to check (entry_count of
// them, the count before the command) and the result beat shows in the first
// cycle with busy low again; on an empty store it behaves like insert and
// delete-at-position. Results cannot be held off; each beat is valid for the
// single cycle that strobe is high. No clearing pass is needed after reset.
module positional_sequence_store #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  pss_pkg::t_in  i_item,
    output logic          busy,
    output logic          strobe,
    output pss_pkg::t_out o_result
);

    localparam int PW = pss_pkg::PW;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic               r_busy, n_busy;
    logic               r_strobe, n_strobe;
    logic               r_rej, n_rej;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_left, n_left;
    logic signed [31:0] r_key, n_key;

    pss_pkg::t_ctl   ctl;
    pss_pkg::t_entry new_entry;
    pss_pkg::t_entry cells [CAPACITY];

    logic          accept;
    logic [PW-1:0] pos_w, cnt_w, pos_clamp;

    assign accept    = start && !r_busy;
    assign pos_w     = PW'(i_item.position);
    assign cnt_w     = PW'(r_count);
    assign pos_clamp = (pos_w > cnt_w) ? cnt_w : pos_w;

    assign new_entry.handle = i_item.node_handle;
    assign new_entry.key    = i_item.node_key;
    assign new_entry.symbol = i_item.symbol;

    always_comb begin
        n_busy   = r_busy;
        n_strobe = 1'b0;
        n_rej    = r_rej;
        n_count  = r_count;
        n_left   = r_left;
        n_key    = r_key;
        ctl.op   = pss_pkg::OP_HOLD;
        ctl.pos  = pos_clamp;
        ctl.keep = 1'b0;
        if (r_busy) begin
            ctl.op   = pss_pkg::OP_ROT;
            ctl.pos  = PW'(r_count - 1'b1);
            ctl.keep = (cells[0].key != r_key);
            if (!ctl.keep) begin
                n_count = r_count - 1'b1;
            end
            n_left = r_left - 1'b1;
            if (r_left == CW'(1)) begin
                n_busy   = 1'b0;
                n_strobe = 1'b1;
            end
        end else if (accept) begin
            n_rej = 1'b0;
            unique case (i_item.func)
                pss_pkg::FN_INSERT: begin
                    n_strobe = 1'b1;
                    if (r_count == CAP_C) begin
                        n_rej = 1'b1;
                    end else begin
                        ctl.op  = pss_pkg::OP_INS;
                        n_count = r_count + 1'b1;
                    end
                end
                pss_pkg::FN_DEL_POS: begin
                    n_strobe = 1'b1;
                    if (pos_w < cnt_w) begin
                        ctl.op  = pss_pkg::OP_DEL;
                        ctl.pos = pos_w;
                        n_count = r_count - 1'b1;
                    end
                end
                pss_pkg::FN_DEL_KEY: begin
                    n_key = i_item.node_key;
                    if (r_count == '0) begin
                        n_strobe = 1'b1;
                    end else begin
                        n_busy = 1'b1;
                        n_left = r_count;
                    end
                end
                default: begin
                    n_strobe = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_rej    <= 1'b0;
            r_count  <= '0;
            r_left   <= '0;
        end else begin
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
            r_rej    <= n_rej;
            r_count  <= n_count;
            r_left   <= n_left;
        end
        r_key <= n_key;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pss_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_prev  ((g == 0) ? new_entry : cells[(g == 0) ? 0 : g - 1]),
            .i_next  ((g == CAPACITY - 1) ? new_entry
                                          : cells[(g == CAPACITY - 1) ? g : g + 1]),
            .i_new   (new_entry),
            .i_head  (cells[0]),
            .o_entry (cells[g])
        );
    end

    assign busy   = r_busy;
    assign strobe = r_strobe;

    assign o_result.head_handle = (r_count == '0) ? 16'd0 : cells[0].handle;
    assign o_result.head_symbol = (r_count == '0) ? 8'd0 : cells[0].symbol;
    assign o_result.is_vacant   = (r_count == '0);
    assign o_result.entry_count = 5'(r_count);
    assign o_result.rejected    = r_rej;

`ifndef SYNTHESIS
    a_no_beat_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_strobe && r_busy))
        else $error("result beat during key scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("count above capacity");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_rej) |-> (r_count == CAP_C))
        else $error("reject reported on a store that is not full");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.func == pss_pkg::FN_INSERT && r_count != CAP_C)
        |=> (r_strobe && r_count == $past(r_count) + 1'b1))
        else $error("insert did not add an entry");

    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0 && r_left <= r_count + (CW'(r_count) == r_left ? '0 : r_left)))
        else $error("key scan step count lost");
`endif

endmodule
